// File: hdl/sjfq_pkg.sv
// Shared types and constants of the shortest-job-first queue with aging.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package sjfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MODEL_W         = 8;
    localparam int JOB_TIME_W      = 16;
    localparam int SLOT_TIME_W     = 17;
    localparam int WAIT_W          = 5;
    localparam int PERIOD_W        = 8;
    localparam int AGE_W           = 9;

    localparam logic [PERIOD_W-1:0] AGING_PERIOD_RST = 8'd2;

    typedef struct packed {
        logic                  add_job;
        logic [MODEL_W-1:0]    job_model;
        logic [JOB_TIME_W-1:0] job_time;
        logic                  do_tick;
    } req_t;

    typedef struct packed {
        logic               done_valid;
        logic [MODEL_W-1:0] done_model;
        logic               insert_dropped;
        logic [WAIT_W-1:0]  jobs_waiting;
    } res_t;

    typedef struct packed {
        logic [MODEL_W-1:0]     model;
        logic [SLOT_TIME_W-1:0] jtime;
    } entry_t;

endpackage

// File: hdl/sjfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sjfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/sjf_queue_with_aging_top.sv
// Top level of the shortest-job-first queue with aging.
// Depends on sjfq_pkg and sjfq_ram.
// Timing is set by the sorted-insert walk over the job RAM (one entry per cycle)
// and by the head read of a tick.
// Throughput: one request at a time; a new request is taken once the result
// is in the output register, even while that result still waits.
// Reset: control state cleared, aging period set to 2; RAM contents are kept.
`timescale 1ns / 1ps

module sjf_queue_with_aging_top #(
    parameter int QUEUE_DEPTH = sjfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    output logic                                job_ready,
    input  sjfq_pkg::req_t                      job,
    output logic                                res_valid,
    input  logic                                res_ready,
    output sjfq_pkg::res_t                      res,
    input  logic                                cfg_we,
    input  logic [sjfq_pkg::PERIOD_W-1:0]       cfg_wdata
);

    import sjfq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W    = (AW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INS_RD  = 9'b000000010,
        S_INS_CMP = 9'b000000100,
        S_INS_PUT = 9'b000001000,
        S_TICK    = 9'b000010000,
        S_AGE_RD  = 9'b000100000,
        S_AGE_WT  = 9'b001000000,
        S_HEAD_RD = 9'b010000000,
        S_HEAD_WT = 9'b100000000
    } state_t;

    localparam state_t S_FIN_NONE = S_IDLE;

    state_t                  state_reg, state_next;
    logic                    fin_reg, fin_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [CW-1:0]           count_reg, count_next;
    logic signed [AGE_W-1:0] age_reg, age_next;
    logic [PERIOD_W-1:0]     period_reg, period_next;
    logic [AW-1:0]           idx_reg, idx_next;
    entry_t                  new_reg, new_next;
    logic                    tick_reg, tick_next;
    logic                    aging_reg, aging_next;
    logic                    dropped_reg, dropped_next;
    logic                    done_v_reg, done_v_next;
    logic [MODEL_W-1:0]      done_m_reg, done_m_next;
    logic                    res_valid_reg, res_valid_next;
    res_t                    res_reg, res_next;

    logic                    ram_we;
    logic [AW-1:0]           waddr_off, raddr_off;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    entry_t                  ram_wdata;
    logic [$bits(entry_t)-1:0] ram_rdata_raw;
    entry_t                  ram_rdata;
    logic [CW+WAIT_W-1:0]    count_ext;
    logic                    age_due;
    logic                    age_room;

    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                                 input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    sjfq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);
    assign ram_waddr = wrap_addr(head_reg, waddr_off);
    assign ram_raddr = wrap_addr(head_reg, raddr_off);
    assign count_ext = {{WAIT_W{1'b0}}, count_reg};
    assign age_due   = age_reg >= $signed({1'b0, period_reg});
    assign age_room  = age_reg < $signed({1'b0, period_reg});

    assign job_ready = (state_reg == S_IDLE) && !fin_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        fin_next       = fin_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        age_next       = age_reg;
        period_next    = cfg_we ? cfg_wdata : period_reg;
        idx_next       = idx_reg;
        new_next       = new_reg;
        tick_next      = tick_reg;
        aging_next     = aging_reg;
        dropped_next   = dropped_reg;
        done_v_next    = done_v_reg;
        done_m_next    = done_m_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        ram_we         = 1'b0;
        waddr_off      = idx_reg;
        raddr_off      = '0;
        ram_wdata      = new_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (fin_reg)
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_next          = 1'b1;
                        res_next.done_valid     = done_v_reg;
                        res_next.done_model     = done_m_reg;
                        res_next.insert_dropped = dropped_reg;
                        res_next.jobs_waiting   = count_ext[WAIT_W-1:0];
                        fin_next                = 1'b0;
                    end
                end
                else if (job_valid)
                begin
                    tick_next    = job.do_tick;
                    new_next     = '{model: job.job_model, jtime: {1'b0, job.job_time}};
                    dropped_next = 1'b0;
                    done_v_next  = 1'b0;
                    done_m_next  = '0;
                    aging_next   = 1'b0;
                    if (job.add_job && count_reg != COUNT_FULL)
                    begin
                        count_next = count_reg + COUNT_ONE;
                        idx_next   = count_reg[AW-1:0];
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        dropped_next = job.add_job;
                        if (job.do_tick)
                        begin
                            state_next = S_TICK;
                        end
                        else
                        begin
                            fin_next = 1'b1;
                        end
                    end
                end
            end

            S_INS_RD, S_INS_CMP, S_INS_PUT:
            begin
                if (state_reg == S_INS_RD && idx_reg != '0)
                begin
                    raddr_off  = idx_reg - AW'(1);
                    state_next = S_INS_CMP;
                end
                else if (state_reg == S_INS_CMP && ram_rdata.jtime > new_reg.jtime)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        raddr_off = idx_reg - AW'(2);
                    end
                end
                else
                begin
                    ram_we = 1'b1;
                    if (aging_reg)
                    begin
                        state_next = S_HEAD_RD;
                    end
                    else if (tick_reg)
                    begin
                        state_next = S_TICK;
                    end
                    else
                    begin
                        state_next = S_FIN_NONE;
                        fin_next   = 1'b1;
                    end
                end
            end

            S_TICK:
            begin
                if (count_reg == '0)
                begin
                    if (age_room)
                    begin
                        age_next = age_reg + 9'sd1;
                    end
                    state_next = S_FIN_NONE;
                    fin_next   = 1'b1;
                end
                else if (age_due && count_reg > COUNT_ONE)
                begin
                    age_next   = -9'sd1;
                    aging_next = 1'b1;
                    state_next = S_AGE_RD;
                end
                else
                begin
                    state_next = S_HEAD_RD;
                end
            end

            S_AGE_RD:
            begin
                raddr_off  = count_reg[AW-1:0] - AW'(1);
                state_next = S_AGE_WT;
            end

            S_AGE_WT:
            begin
                new_next.model = ram_rdata.model;
                new_next.jtime = (ram_rdata.jtime == '0) ? '0 :
                                 ram_rdata.jtime - SLOT_TIME_W'(1);
                idx_next       = count_reg[AW-1:0] - AW'(1);
                state_next     = S_INS_RD;
            end

            S_HEAD_RD:
            begin
                state_next = S_HEAD_WT;
            end

            S_HEAD_WT:
            begin
                if (ram_rdata.jtime <= SLOT_TIME_W'(1))
                begin
                    done_v_next = 1'b1;
                    done_m_next = ram_rdata.model;
                    head_next   = wrap_addr(head_reg, AW'(1));
                    count_next  = count_reg - COUNT_ONE;
                end
                else
                begin
                    ram_we          = 1'b1;
                    waddr_off       = '0;
                    ram_wdata.model = ram_rdata.model;
                    ram_wdata.jtime = ram_rdata.jtime - SLOT_TIME_W'(1);
                    if (age_room)
                    begin
                        age_next = age_reg + 9'sd1;
                    end
                end
                state_next = S_FIN_NONE;
                fin_next   = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fin_reg       <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            age_reg       <= '0;
            period_reg    <= AGING_PERIOD_RST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            age_reg       <= age_next;
            period_reg    <= period_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        new_reg     <= new_next;
        tick_reg    <= tick_next;
        aging_reg   <= aging_next;
        dropped_reg <= dropped_next;
        done_v_reg  <= done_v_next;
        done_m_reg  <= done_m_next;
        res_reg     <= res_next;
    end

endmodule

// File: hdl/sjfq_checker.sv
// Port-level checker for the shortest-job-first queue with aging.
// Depends on sjfq_pkg; bound to sjf_queue_with_aging_top below.
`timescale 1ns / 1ps

module sjfq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           job_valid,
    input logic           job_ready,
    input logic           res_valid,
    input logic           res_ready,
    input sjfq_pkg::res_t res
);

    import sjfq_pkg::*;

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> !job_ready)
        else $error("ready stayed high after a request");

    a_no_model_without_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.done_valid |-> res.done_model == '0)
        else $error("done_model set without a finished job");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result changed");

    a_result_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !job_ready || $past(!job_ready))
        else $error("result appeared without a request in flight");

endmodule

bind sjf_queue_with_aging_top sjfq_checker u_sjfq_checker (.*);

// File: tb/tb_sjf_queue_with_aging_top.sv
// Self-checking testbench for sjf_queue_with_aging_top: a short directed table, then
// random phases under several aging periods, each result checked against a job-queue predictor.
// Depends on sjfq_pkg and the RTL of sjf_queue_with_aging_top.
`timescale 1ns / 1ps

module tb_sjf_queue_with_aging_top;

    localparam int QDEPTH       = sjfq_pkg::QUEUE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 2 * QDEPTH + 9;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASES       = 6;
    localparam int DRAW_PERIOD  = 256;
    localparam int SCRIPT_ROWS  = 14;

    typedef struct packed {
        logic [7:0]     reps;
        sjfq_pkg::req_t req;
        logic           fixed;
        sjfq_pkg::res_t outcome;
    } script_row_t;

    logic           clk;
    logic           rst_n;
    logic           job_valid;
    logic           job_ready;
    sjfq_pkg::req_t job;
    logic           res_valid;
    logic           res_ready;
    sjfq_pkg::res_t res;
    logic           cfg_we;
    logic [sjfq_pkg::PERIOD_W-1:0] cfg_wdata;

    logic           use_fixed;
    sjfq_pkg::res_t fixed_exp;
    logic           calm;
    int             rx_hold;

    logic [7:0]     slot_id   [QDEPTH];
    logic [16:0]    slot_left [QDEPTH];
    int             depth_used;
    int             age_ctr;
    logic [7:0]     boost_period;

    sjfq_pkg::res_t expected_results[$];
    int             fail_count;
    int             requests_taken;
    int             jobs_finished;
    int             inserts_refused;
    int             queue_peak;
    int             cycles;

    int phase_period [PHASES] = '{255, 1, 0, 3, DRAW_PERIOD, DRAW_PERIOD};
    int add_pct      [PHASES] = '{55, 50, 65, 85, 50, 55};
    int tick_pct     [PHASES] = '{75, 80, 65, 35, 70, 70};

    script_row_t script [SCRIPT_ROWS] = '{
        '{8'd1,  '{1'b0, 8'h00, 16'h0000, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b0, 5'd0}},
        '{8'd1,  '{1'b0, 8'hFF, 16'hFFFF, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 5'd0}},
        '{8'd1,  '{1'b1, 8'hFF, 16'h0000, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 5'd1}},
        '{8'd1,  '{1'b0, 8'h00, 16'h0000, 1'b1}, 1'b1, '{1'b1, 8'hFF, 1'b0, 5'd0}},
        '{8'd1,  '{1'b1, 8'h00, 16'hFFFF, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 5'd1}},
        '{8'd1,  '{1'b1, 8'hAA, 16'h0001, 1'b1}, 1'b1, '{1'b1, 8'hAA, 1'b0, 5'd1}},
        '{8'd1,  '{1'b1, 8'h55, 16'h0003, 1'b1}, 1'b0, '0},
        '{8'd1,  '{1'b0, 8'h00, 16'h0000, 1'b1}, 1'b0, '0},
        '{8'd1,  '{1'b0, 8'h00, 16'h0000, 1'b1}, 1'b0, '0},
        '{8'd14, '{1'b1, 8'h3C, 16'h0004, 1'b0}, 1'b0, '0},
        '{8'd1,  '{1'b1, 8'h81, 16'h0002, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 5'd16}},
        '{8'd1,  '{1'b1, 8'h7E, 16'h7FFF, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b1, 5'd16}},
        '{8'd1,  '{1'b1, 8'h7E, 16'h0001, 1'b1}, 1'b0, '0},
        '{8'd2,  '{1'b0, 8'h00, 16'h0000, 1'b1}, 1'b0, '0}
    };

    sjf_queue_with_aging_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic void enqueue_job(input logic [7:0] id, input logic [16:0] t);
        int pos;
        pos = depth_used;
        for (int i = 0; i < depth_used; i++)
        begin
            if (t < slot_left[i])
            begin
                pos = i;
                break;
            end
        end
        for (int i = depth_used; i > pos; i--)
        begin
            slot_id[i]   = slot_id[i - 1];
            slot_left[i] = slot_left[i - 1];
        end
        slot_id[pos]   = id;
        slot_left[pos] = t;
        depth_used++;
    endfunction

    function automatic sjfq_pkg::res_t run_schedule(input sjfq_pkg::req_t r);
        sjfq_pkg::res_t o;
        logic [7:0]     tail_id;
        logic [16:0]    tail_left;
        bit             popped;
        o = '0;
        popped = 1'b0;
        if (r.add_job)
        begin
            if (depth_used >= QDEPTH)
                o.insert_dropped = 1'b1;
            else
                enqueue_job(r.job_model, {1'b0, r.job_time});
        end
        if (r.do_tick)
        begin
            if (depth_used > 0)
            begin
                if (age_ctr >= int'(boost_period) && depth_used > 1)
                begin
                    tail_id   = slot_id[depth_used - 1];
                    tail_left = slot_left[depth_used - 1];
                    if (tail_left != 0)
                        tail_left = tail_left - 1'b1;
                    depth_used--;
                    enqueue_job(tail_id, tail_left);
                    age_ctr = -1;
                end
                if (slot_left[0] <= 1)
                begin
                    o.done_valid = 1'b1;
                    o.done_model = slot_id[0];
                    for (int i = 1; i < depth_used; i++)
                    begin
                        slot_id[i - 1]   = slot_id[i];
                        slot_left[i - 1] = slot_left[i];
                    end
                    depth_used--;
                    popped = 1'b1;
                end
                else
                begin
                    slot_left[0] = slot_left[0] - 1'b1;
                end
            end
            if (!popped && age_ctr < int'(boost_period))
                age_ctr++;
        end
        if (depth_used > queue_peak)
            queue_peak = depth_used;
        o.jobs_waiting = 5'(depth_used);
        return o;
    endfunction

    function automatic void compare_finish(input sjfq_pkg::res_t got);
        sjfq_pkg::res_t want;
        if (got.done_valid)
            jobs_finished++;
        if (got.insert_dropped)
            inserts_refused++;
        if (expected_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("[%0t] unexpected result: done=%0b model=%02h dropped=%0b waiting=%0d",
                         $realtime, got.done_valid, got.done_model, got.insert_dropped,
                         got.jobs_waiting);
            return;
        end
        want = expected_results.pop_front();
        if (got.done_valid !== want.done_valid || got.done_model !== want.done_model ||
            got.insert_dropped !== want.insert_dropped ||
            got.jobs_waiting !== want.jobs_waiting)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("[%0t] mismatch: expected done=%0b model=%02h dropped=%0b waiting=%0d, got done=%0b model=%02h dropped=%0b waiting=%0d",
                         $realtime, want.done_valid, want.done_model, want.insert_dropped,
                         want.jobs_waiting, got.done_valid, got.done_model,
                         got.insert_dropped, got.jobs_waiting);
        end
    endfunction

    function automatic sjfq_pkg::req_t random_request(input int add_p, input int tick_p);
        sjfq_pkg::req_t r;
        int pick;
        r.add_job   = ($urandom_range(0, 99) < add_p);
        r.do_tick   = ($urandom_range(0, 99) < tick_p);
        r.job_model = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (!r.add_job || pick == 0)
            r.job_time = 16'($urandom());
        else if (pick < 6)
            r.job_time = '0;
        else
            r.job_time = 16'($urandom_range(1, 12));
        return r;
    endfunction

    task automatic send_request(input sjfq_pkg::req_t r, input logic fixed,
                                input sjfq_pkg::res_t outcome);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            job_valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge clk);
        end
        job       <= r;
        use_fixed <= fixed;
        fixed_exp <= outcome;
        job_valid <= 1'b1;
        do @(posedge clk); while (!job_ready);
        @(negedge clk);
    endtask

    task automatic write_period(input logic [7:0] p);
        job_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        cfg_wdata <= p;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we       <= 1'b0;
        boost_period = p;
    endtask

    always @(negedge clk)
    begin
        if (calm || !rst_n)
        begin
            res_ready <= 1'b1;
        end
        else if (rx_hold != 0)
        begin
            rx_hold = rx_hold - 1;
            res_ready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            rx_hold = $urandom_range(0, 6);
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : scoreboard
        sjfq_pkg::res_t predicted;
        if (rst_n)
        begin
            if (res_valid && res_ready)
                compare_finish(res);
            if (job_valid && job_ready)
            begin
                predicted = run_schedule(job);
                expected_results.push_back(use_fixed ? fixed_exp : predicted);
                requests_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int p;
        clk             = 1'b0;
        rst_n           = 1'b0;
        job_valid       = 1'b0;
        job             = '0;
        res_ready       = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        use_fixed       = 1'b0;
        fixed_exp       = '0;
        calm            = 1'b0;
        rx_hold         = 0;
        depth_used      = 0;
        age_ctr         = 0;
        boost_period    = sjfq_pkg::AGING_PERIOD_RST;
        fail_count      = 0;
        requests_taken  = 0;
        jobs_finished   = 0;
        inserts_refused = 0;
        queue_peak      = 0;
        cycles          = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < SCRIPT_ROWS; k++)
        begin
            repeat (script[k].reps)
                send_request(script[k].req, script[k].fixed, script[k].outcome);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            p = (phase_period[ph] == DRAW_PERIOD) ? $urandom_range(1, 255) : phase_period[ph];
            write_period(8'(p));
            calm = (ph == PHASES - 1);
            repeat (120)
                send_request(random_request(add_pct[ph], tick_pct[ph]), 1'b0, '0);
        end

        job_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            fail_count++;

        $display("Ran %0d requests over %0d aging-period settings including 0, 1 and 255;",
                 requests_taken, PHASES + 1);
        $display("%0d jobs finished, %0d inserts refused on a full queue, queue peak %0d.",
                 jobs_finished, inserts_refused, queue_peak);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
hdl/sjfq_pkg.sv
hdl/sjfq_ram.sv
hdl/sjf_queue_with_aging_top.sv
hdl/sjfq_checker.sv
tb/tb_sjf_queue_with_aging_top.sv
